@@ rtl/r8ts_pkg.sv @@
// Shared constants and codes for the RGBA8 4x4 tile swizzle encoder.
// No dependencies; imported by the top level.
package r8ts_pkg;

    localparam int TILE_SIDE   = 4;
    localparam int CFG_W       = 11;
    localparam int ROW_W       = 3;
    localparam int TOP_W       = 11;
    localparam int OFFSET_W    = 23;
    localparam int OUT_OFS_W   = 22;
    localparam int WORD_W      = 5;
    localparam int HEIGHT_MAX  = 1024;
    localparam int PIXEL_W     = 32;

    localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(2 * TILE_SIDE * TILE_SIDE - 1);

    // Result kinds carried on the output tuser.
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_WORD   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Item kinds carried on the input tuser.
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_EMIT  = 1'b1;

    // Register index taken from the word address.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

@@ rtl/rgba8_tile_swizzle_encoder.sv @@
// RGBA8 raster to 4x4 tiled texture encoder (alpha/red then green/blue pairs).
// Depends on r8ts_pkg and r8ts_ram (the four-row band line store).
// A result passes through the store read stage and then the output register after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the single write and single
// read port of the line store each serve at most one access per item.
// Reset clears all counters, flags and both size registers to one; the line store is not cleared.
module rgba8_tile_swizzle_encoder #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Pixel and emit items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic [0:0]  s_tuser,   // action[0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // first_byte[7:0], second_byte[15:8], byte_offset[37:16]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,   // last_of_image
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import r8ts_pkg::*;

    localparam int DEPTH = TILE_SIDE * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int TA_W  = $clog2((MAX_WIDTH + 3) / 4 + 1);
    localparam int XW    = TA_W + 2;
    localparam int CW    = (XW > EW) ? XW + 1 : EW + 1;

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_write;

    // Stream control state
    logic [COL_W-1:0]    fill_column_reg, fill_column_next;
    logic [ROW_W-1:0]    fill_row_reg, fill_row_next;
    logic [TOP_W-1:0]    band_top_reg, band_top_next;
    logic                band_ready_reg, band_ready_next;
    logic [TA_W-1:0]     tile_col_reg, tile_col_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    // Read stage and output register
    logic                 s1_valid_reg;
    logic [1:0]           s1_status_reg;
    logic                 s1_half_reg;
    logic                 s1_use_reg;
    logic [OUT_OFS_W-1:0] s1_offset_reg;
    logic                 s1_last_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [7:0]           out_first_reg;
    logic [7:0]           out_second_reg;
    logic [OUT_OFS_W-1:0] out_offset_reg;
    logic                 out_last_reg;

    logic adv1, accept, is_emit, store_ok, emit_ok;

    logic [EW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [CFG_W-1:0] padded_h;
    logic [TA_W-1:0]  tiles_across;

    logic [EW-1:0]    col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             store_ready_set;

    logic [XW-1:0]    emit_x;
    logic [1:0]       emit_r;
    logic             emit_use;
    logic             tile_done;
    logic             band_done;
    logic             emit_last;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PIXEL_W-1:0] ram_rdata;

    // ---------------------------------------------------------------- configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                width_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Zero sizes count as one, oversize values are clamped.
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = EW'(1);
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(width_reg);

        priority if (height_reg == '0)
            h_eff = CFG_W'(1);
        else if (height_reg > CFG_W'(HEIGHT_MAX))
            h_eff = CFG_W'(HEIGHT_MAX);
        else
            h_eff = height_reg;

        padded_h     = (h_eff + CFG_W'(3)) & ~CFG_W'(3);
        tiles_across = TA_W'(((EW + 1)'(w_eff) + (EW + 1)'(3)) >> 2);
    end

    // ---------------------------------------------------------------- handshake
    assign adv1     = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv1;
    assign accept   = s_tvalid && s_tready;
    assign is_emit  = (s_tuser[0] == ACT_EMIT);
    assign store_ok = accept && !is_emit && !band_ready_reg;
    assign emit_ok  = accept && is_emit && band_ready_reg;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        col_inc         = EW'(fill_column_reg) + EW'(1);
        row_inc         = fill_row_reg + ROW_W'(1);
        store_ready_set = (row_inc >= ROW_W'(TILE_SIDE))
                       || ((TOP_W + 1)'(band_top_reg) + (TOP_W + 1)'(row_inc)
                           >= (TOP_W + 1)'(h_eff));

        emit_x    = {tile_col_reg, word_reg[1:0]};
        emit_r    = word_reg[3:2];
        emit_use  = (CW'(emit_x) < CW'(w_eff)) && (ROW_W'(emit_r) < fill_row_reg);
        tile_done = (TA_W + 1)'(tile_col_reg) + (TA_W + 1)'(1) >= (TA_W + 1)'(tiles_across);
        band_done = (TOP_W + 1)'(band_top_reg) + (TOP_W + 1)'(TILE_SIDE)
                 >= (TOP_W + 1)'(padded_h);
        emit_last = (word_reg == WORD_LAST) && tile_done && band_done;

        fill_column_next = fill_column_reg;
        fill_row_next    = fill_row_reg;
        band_top_next    = band_top_reg;
        band_ready_next  = band_ready_reg;
        tile_col_next    = tile_col_reg;
        word_next        = word_reg;
        offset_next      = offset_reg;

        if (cfg_write)
        begin
            fill_column_next = '0;
            fill_row_next    = '0;
            band_top_next    = '0;
            band_ready_next  = 1'b0;
            tile_col_next    = '0;
            word_next        = '0;
            offset_next      = '0;
        end
        else if (store_ok)
        begin
            if (col_inc >= w_eff)
            begin
                fill_column_next = '0;
                fill_row_next    = row_inc;
                band_ready_next  = store_ready_set;
            end
            else
            begin
                fill_column_next = COL_W'(col_inc);
            end
        end
        else if (emit_ok)
        begin
            offset_next = offset_reg + OFFSET_W'(2);
            word_next   = word_reg + WORD_W'(1);
            if (word_reg == WORD_LAST)
            begin
                word_next = '0;
                if (tile_done)
                begin
                    // Band finished: go back to filling the next four rows.
                    tile_col_next    = '0;
                    band_ready_next  = 1'b0;
                    fill_row_next    = '0;
                    fill_column_next = '0;
                    if (band_done)
                    begin
                        band_top_next = '0;
                        offset_next   = '0;
                    end
                    else
                    begin
                        band_top_next = band_top_reg + TOP_W'(TILE_SIDE);
                    end
                end
                else
                begin
                    tile_col_next = tile_col_reg + TA_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_column_reg <= '0;
            fill_row_reg    <= '0;
            band_top_reg    <= '0;
            band_ready_reg  <= 1'b0;
            tile_col_reg    <= '0;
            word_reg        <= '0;
            offset_reg      <= '0;
        end
        else
        begin
            fill_column_reg <= fill_column_next;
            fill_row_reg    <= fill_row_next;
            band_top_reg    <= band_top_next;
            band_ready_reg  <= band_ready_next;
            tile_col_reg    <= tile_col_next;
            word_reg        <= word_next;
            offset_reg      <= offset_next;
        end
    end

    // ---------------------------------------------------------------- line store
    // Stores happen only while the band fills and reads only while it drains, so a
    // read never meets a write to the same entry in one cycle.
    assign ram_we    = store_ok;
    assign ram_waddr = AW'(fill_row_reg) * AW'(MAX_WIDTH) + AW'(fill_column_reg);
    assign ram_re    = emit_ok && emit_use;
    assign ram_raddr = AW'(emit_r) * AW'(MAX_WIDTH) + AW'(emit_x);

    r8ts_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_band_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= emit_ok ? ST_WORD : (store_ok ? ST_STORED : ST_REJECT);
            s1_half_reg   <= word_reg[4];
            s1_use_reg    <= emit_ok && emit_use;
            s1_offset_reg <= emit_ok ? offset_reg[OUT_OFS_W-1:0] : '0;
            s1_last_reg   <= emit_ok && emit_last;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_offset_reg <= s1_offset_reg;
            out_last_reg   <= s1_last_reg;
            if (!s1_use_reg)
            begin
                out_first_reg  <= 8'd0;
                out_second_reg <= 8'd0;
            end
            else if (s1_half_reg)
            begin
                out_first_reg  <= ram_rdata[15:8];
                out_second_reg <= ram_rdata[23:16];
            end
            else
            begin
                out_first_reg  <= ram_rdata[31:24];
                out_second_reg <= ram_rdata[7:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_offset_reg, out_second_reg, out_first_reg};

    // ---------------------------------------------------------------- checks
    a_last_is_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == ST_WORD)
        else $error("end-of-image mark on an item that is not an output word");

    a_ready_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
        band_ready_reg |-> fill_row_reg != '0)
        else $error("band marked ready with no stored rows");

    a_drain_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (word_reg != '0 || tile_col_reg != '0) |-> band_ready_reg)
        else $error("emit position advanced while the band is filling");

    a_offset_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[16])
        else $error("output byte offset is odd");

endmodule

@@ rtl/r8ts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module r8ts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ verif/rgba8_tile_swizzle_encoder_tb.sv @@
// Self-checking testbench for rgba8_tile_swizzle_encoder: raster pixels go in and the
// tiled alpha/red and green/blue words coming out are checked against a built-in predictor.
// Depends on r8ts_pkg and the encoder RTL only.
module rgba8_tile_swizzle_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import r8ts_pkg::*;

    localparam int STORE_COLS  = 1024;
    localparam int TILE_PIXELS = TILE_SIDE * TILE_SIDE;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [21:0] byte_offset;
        logic        last_of_image;
    } tile_word_t;

    // Tracks the encoder's band store and counters and queues the word each item should give.
    class tile_word_scoreboard;
        logic [31:0] band_rows [TILE_SIDE * STORE_COLS];
        logic [10:0] width_reg;
        logic [10:0] height_reg;
        int unsigned fill_col;
        int unsigned fill_row;
        int unsigned band_top;
        int unsigned tile_col;
        int unsigned word_idx;
        logic [22:0] next_offset;
        bit          band_ready;
        bit          image_done;
        tile_word_t  expected_words [$];
        int          errors;

        function new();
            width_reg = 11'd1;
            height_reg = 11'd1;
            errors = 0;
            restart();
        endfunction

        function void restart();
            fill_col = 0;
            fill_row = 0;
            band_top = 0;
            tile_col = 0;
            word_idx = 0;
            next_offset = '0;
            band_ready = 1'b0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == REG_WIDTH)
                width_reg = value[10:0];
            else
                height_reg = value[10:0];
            restart();
        endfunction

        function void take_item(logic act, logic [31:0] pix);
            int unsigned w;
            int unsigned h;
            int unsigned tiles;
            int unsigned padded_h;
            int unsigned pos;
            int unsigned x;
            int unsigned r;
            logic [31:0] v;
            tile_word_t want;
            w = (width_reg == 0) ? 1 : width_reg;
            if (w > STORE_COLS)
                w = STORE_COLS;
            h = (height_reg == 0) ? 1 : height_reg;
            if (h > HEIGHT_MAX)
                h = HEIGHT_MAX;
            tiles = (w + TILE_SIDE - 1) / TILE_SIDE;
            padded_h = (h + 3) & ~32'd3;
            want = '0;
            want.status = ST_REJECT;
            if (act == ACT_STORE)
            begin
                if (!band_ready)
                begin
                    band_rows[fill_row * STORE_COLS + fill_col] = pix;
                    fill_col++;
                    if (fill_col >= w)
                    begin
                        fill_col = 0;
                        fill_row++;
                        // A short last band is complete once the bottom image row is in.
                        if (fill_row >= TILE_SIDE || band_top + fill_row >= h)
                            band_ready = 1'b1;
                    end
                    want.status = ST_STORED;
                end
            end
            else if (band_ready)
            begin
                pos = word_idx % TILE_PIXELS;
                x = tile_col * TILE_SIDE + pos % TILE_SIDE;
                r = pos / TILE_SIDE;
                if (x < w && r < fill_row)
                begin
                    v = band_rows[r * STORE_COLS + x];
                    if (word_idx < TILE_PIXELS)
                    begin
                        want.first_byte = v[31:24];
                        want.second_byte = v[7:0];
                    end
                    else
                    begin
                        want.first_byte = v[15:8];
                        want.second_byte = v[23:16];
                    end
                end
                want.status = ST_WORD;
                want.byte_offset = next_offset[21:0];
                want.last_of_image = (word_idx == WORD_LAST) && (tile_col + 1 >= tiles)
                    && (band_top + TILE_SIDE >= padded_h);
                if (want.last_of_image)
                    image_done = 1'b1;
                next_offset = next_offset + 23'd2;
                word_idx++;
                if (word_idx > WORD_LAST)
                begin
                    word_idx = 0;
                    tile_col++;
                    if (tile_col >= tiles)
                    begin
                        tile_col = 0;
                        band_ready = 1'b0;
                        fill_row = 0;
                        fill_col = 0;
                        band_top += TILE_SIDE;
                        if (band_top >= padded_h)
                        begin
                            band_top = 0;
                            next_offset = '0;
                        end
                    end
                end
            end
            expected_words.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(tile_word_t got);
            tile_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("result item with nothing expected, status %0d", got.status);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("first_byte", want.first_byte, got.first_byte);
            compare_field("second_byte", want.second_byte, got.second_byte);
            compare_field("byte_offset", want.byte_offset, got.byte_offset);
            compare_field("last_of_image", want.last_of_image, got.last_of_image);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic [0:0]  s_tuser;   // action[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // first_byte[7:0], second_byte[15:8], byte_offset[37:16]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tile_word_scoreboard sb = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit stall_request;
    int good_items;

    rgba8_tile_swizzle_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Receiver: random back-pressure, plus one long hold-off when asked for.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        tile_word_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.first_byte = m_tdata[7:0];
            got.second_byte = m_tdata[15:8];
            got.byte_offset = m_tdata[37:16];
            got.last_of_image = m_tlast;
            sb.check_word(got);
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic act, input logic [31:0] pix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = pix;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(act, pix);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Both size registers, in random order; upper bits sometimes carry junk the block must drop.
    task automatic configure(input int w, input int h);
        logic [31:0] wv;
        logic [31:0] hv;
        drain();
        wv = {($urandom_range(3) == 0) ? 21'($urandom) : 21'd0, 11'(w)};
        hv = {($urandom_range(3) == 0) ? 21'($urandom) : 21'd0, 11'(h)};
        if ($urandom_range(1) == 0)
        begin
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
        end
        else
        begin
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_WIDTH, wv);
        end
    endtask

    // Mostly the item the block is waiting for, with some out-of-order ones mixed in.
    task automatic run_image(input int item_cap, input int noise_pct);
        int  count;
        bit  odd;
        logic act;
        count = 0;
        sb.image_done = 1'b0;
        while (!sb.image_done && count < item_cap)
        begin
            odd = ($urandom_range(99) < noise_pct);
            act = (sb.band_ready ^ odd) ? ACT_EMIT : ACT_STORE;
            send_item(act, $urandom);
            count++;
            if (!odd)
                good_items++;
        end
    endtask

    initial
    begin
        int w;
        int h;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_STORE;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_request = 1'b0;
        good_items = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 75;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Emit before any pixel is stored is refused.
        send_item(ACT_EMIT, 32'h0);
        // Zero sizes act as one pixel; a pixel while the band waits is refused.
        configure(0, 0);
        send_item(ACT_STORE, 32'hFFFF_FFFF);
        send_item(ACT_STORE, 32'h0000_0000);
        repeat (2 * TILE_PIXELS) send_item(ACT_EMIT, 32'hFFFF_FFFF);
        // After the end of the image the next pixel starts a new one.
        send_item(ACT_EMIT, 32'h0);
        send_item(ACT_STORE, 32'h8001_7F80);
        send_item(ACT_EMIT, 32'h0);
        send_item(ACT_EMIT, 32'h0);
        // Register write in the middle of an image restarts the stream; short last band.
        configure(6, 5);
        run_image(1000, 0);

        good_items = 0;
        while (good_items < RANDOM_ITEMS)
        begin
            if (good_items >= 2 * RANDOM_ITEMS / 3 && tx_idle_pct != 0)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                stall_request = 1'b1;
            end
            else if (good_items >= RANDOM_ITEMS / 3 && good_items < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 75;
                rx_idle_pct = 28;
            end
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
            h = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 9);
            if ($urandom_range(19) == 0)
                w = 0;
            if ($urandom_range(19) == 0)
                h = 0;
            configure(w, h);
            run_image(($urandom_range(3) == 0) ? $urandom_range(1, 80) : 100000, 6);
        end

        // Oversize registers: the row clamps to the widest store, so the band is ready
        // after that many pixels; a tall image is only started.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(2047, 1);
        stall_request = 1'b1;
        run_image(STORE_COLS + TILE_PIXELS, 0);
        configure(1, 2047);
        run_image(80, 2);

        drain();
        repeat (8) @(negedge clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
